### hw/rtl/i2c_register_access_master_core_defines.svh
// ----------------------------------------------------------------------------
// I2C register access master: assertion macros
// Shared concurrent assertion helpers clocked on i_clk; all but the last are held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define I2CRAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define I2CRAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication that is also checked across the reset release
`define I2CRAM_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Command codes, bus operations, line levels and the queued item format.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cram_pkg;

    // Configuration and sizing defaults
    localparam logic [15:0] DELAY_TICKS_RESET = 16'd50;
    localparam int          BURST_BYTES_DEF   = 6;
    localparam int          QUEUE_DEPTH       = 2;
    localparam int          QUEUE_AW          = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);

    // Request command codes
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_WRITE     = 3'd1,
        CMD_READ_BYTE = 3'd2,
        CMD_READ_WORD = 3'd3,
        CMD_BURST     = 3'd4
    } t_cmd;

    // Item classes decided by the front end
    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_REQ  = 2'd1,
        KIND_NOP  = 2'd2
    } t_kind;

    // Bus operations of one transaction
    typedef enum logic [3:0] {
        OP_START      = 4'd0,
        OP_SEND_WADDR = 4'd1,
        OP_SEND_REG   = 4'd2,
        OP_SEND_DATA  = 4'd3,
        OP_SEND_RADDR = 4'd4,
        OP_RECV_ACK   = 4'd5,
        OP_RECV_NACK  = 4'd6,
        OP_STOP       = 4'd7,
        OP_END        = 4'd8
    } t_op;

    // Pin levels: drive enable, data, clock
    typedef struct packed {
        logic drv;
        logic sda;
        logic scl;
    } t_lines;

    localparam t_lines LINES_IDLE = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};

    // Read/write flag appended to the device address
    localparam logic ADDR_RD = 1'b1;
    localparam logic ADDR_WR = 1'b0;

    // One queued beat from the front end to the back end
    typedef struct packed {
        t_kind      kind;
        t_cmd       cmd;
        logic [6:0] slave_addr;
        logic [7:0] reg_index;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_item;

endpackage

`default_nettype wire

### hw/rtl/i2cram_front.sv
// ----------------------------------------------------------------------------
// I2C register access master: front end
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_front
    import i2cram_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [6:0]  i_device_address,
    input  wire logic [7:0]  i_register_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_sda_in,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  wire logic        i_q_pop
);

    t_item                 w_item;
    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  w_push;
    logic                  w_pop;

    // Classify the incoming beat
    always_comb begin
        w_item.cmd        = t_cmd'(i_command);
        w_item.slave_addr = i_device_address;
        w_item.reg_index  = i_register_address;
        w_item.wr_data    = i_write_data;
        w_item.sda_in     = i_sda_in;
        case (i_command)
            CMD_TICK:      w_item.kind = KIND_TICK;
            CMD_WRITE,
            CMD_READ_BYTE,
            CMD_READ_WORD,
            CMD_BURST:     w_item.kind = KIND_REQ;
            default:       w_item.kind = KIND_NOP;
        endcase
    end

    assign o_in_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_item   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the queued beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/i2cram_back.sv
// ----------------------------------------------------------------------------
// I2C register access master: back end
// Runs the transaction sequencer one queued beat per cycle, unless stalled, into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_back
    import i2cram_pkg::*;
#(
    parameter int BURST_BYTES = BURST_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_delay_ticks,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl_level,
    output logic             o_sda_level,
    output logic             o_sda_driving,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [15:0]      o_first_word,
    output logic [15:0]      o_second_word
);

    localparam int SW = $clog2(BURST_BYTES + 7);

    // Map a transaction slot to its bus operation
    function automatic t_op op_of(input t_cmd cmd, input logic [SW-1:0] slot);
        logic [SW-1:0] n;
        t_op           op;
        n  = (cmd == CMD_READ_BYTE) ? SW'(1) :
             (cmd == CMD_READ_WORD) ? SW'(2) : SW'(BURST_BYTES);
        op = OP_END;
        if (cmd == CMD_WRITE) begin
            case (slot)
                SW'(0):  op = OP_START;
                SW'(1):  op = OP_SEND_WADDR;
                SW'(2):  op = OP_SEND_REG;
                SW'(3):  op = OP_SEND_DATA;
                SW'(4):  op = OP_STOP;
                default: op = OP_END;
            endcase
        end else if (slot == SW'(0) || slot == SW'(3)) begin
            op = OP_START;
        end else if (slot == SW'(1)) begin
            op = OP_SEND_WADDR;
        end else if (slot == SW'(2)) begin
            op = OP_SEND_REG;
        end else if (slot == SW'(4)) begin
            op = OP_SEND_RADDR;
        end else if (slot < SW'(5) + n) begin
            op = (slot == SW'(4) + n) ? OP_RECV_NACK : OP_RECV_ACK;
        end else if (slot == SW'(5) + n) begin
            op = OP_STOP;
        end
        return op;
    endfunction

    // Delay units in one operation
    function automatic logic [4:0] op_len(input t_op op);
        logic [4:0] len;
        case (op)
            OP_START:     len = 5'd8;
            OP_STOP:      len = 5'd6;
            OP_RECV_ACK,
            OP_RECV_NACK: len = 5'd20;
            default:      len = 5'd19;
        endcase
        return len;
    endfunction

    // Pin levels driven during one delay unit
    function automatic t_lines unit_levels(input t_op op, input logic [4:0] u,
                                           input t_lines prev, input logic [7:0] tx);
        t_lines     lv;
        logic       b;
        logic [2:0] bi;
        lv = LINES_IDLE;
        case (op)
            OP_START: begin
                if (u < 5'd2) begin
                    lv = '{drv: 1'b1, sda: prev.sda, scl: prev.scl};
                end else if (u < 5'd4) begin
                    lv = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
                end else if (u < 5'd6) begin
                    lv = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
                end else begin
                    lv = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
                end
            end
            OP_STOP: begin
                if (u < 5'd2) begin
                    lv = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
                end else if (u < 5'd4) begin
                    lv = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
                end else begin
                    lv = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
                end
            end
            OP_RECV_ACK, OP_RECV_NACK: begin
                b = (op == OP_RECV_NACK);
                if (u < 5'd16) begin
                    lv = '{drv: 1'b0, sda: 1'b1, scl: u[0]};
                end else if (u == 5'd16) begin
                    lv = '{drv: 1'b1, sda: 1'b1, scl: 1'b0};
                end else if (u == 5'd18) begin
                    lv = '{drv: 1'b1, sda: b, scl: 1'b1};
                end else begin
                    lv = '{drv: 1'b1, sda: b, scl: 1'b0};
                end
            end
            default: begin
                if (u < 5'd17) begin
                    bi = (u < 5'd16) ? u[3:1] : 3'd7;
                    lv = '{drv: 1'b1, sda: tx[3'd7 - bi], scl: (u < 5'd16) && u[0]};
                end else begin
                    lv = '{drv: 1'b0, sda: 1'b1, scl: (u == 5'd18)};
                end
            end
        endcase
        return lv;
    endfunction

    // Sequencer state
    logic             r_busy, n_busy;
    t_cmd             r_cmd, n_cmd;
    logic [6:0]       r_dev, n_dev;
    logic [7:0]       r_reg, n_reg;
    logic [7:0]       r_data, n_data;
    logic [4:0]       r_step, n_step;
    logic [15:0]      r_phase, n_phase;
    logic [2:0]       r_bit, n_bit;
    logic [SW-1:0]    r_slot, n_slot;
    logic [7:0]       r_shift, n_shift;
    logic [15:0]      r_word0, n_word0;
    logic [15:0]      r_word1, n_word1;
    t_lines           r_lines, n_lines;

    // Result register
    logic             r_out_valid;
    t_lines           r_out_lines, n_out_lines;
    logic             r_out_busy;
    logic             r_out_done, n_done;

    t_op              w_op;
    t_lines           w_lv;
    logic [7:0]       w_tx;
    logic [16:0]      w_lim;
    logic             w_unit_end;
    logic [7:0]       w_rx;
    logic [SW-1:0]    w_k;

    assign o_q_pop = !r_out_valid || i_out_ready;

    // Decode the current operation and its levels
    always_comb begin
        w_op = op_of(r_cmd, r_slot);
        case (w_op)
            OP_SEND_WADDR: w_tx = {r_dev, ADDR_WR};
            OP_SEND_REG:   w_tx = r_reg;
            OP_SEND_DATA:  w_tx = r_data;
            default:       w_tx = {r_dev, ADDR_RD};
        endcase
        w_lv       = unit_levels(w_op, r_step, r_lines, w_tx);
        w_lim      = (i_delay_ticks == '0) ? 17'd1 : {1'b0, i_delay_ticks};
        w_unit_end = ({1'b0, r_phase} + 17'd1) >= w_lim;
        w_rx       = {r_shift[6:0], i_q_item.sda_in};
        w_k        = r_slot - SW'(5);
    end

    // Advance the sequencer on a popped beat
    always_comb begin
        n_busy      = r_busy;
        n_cmd       = r_cmd;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_data      = r_data;
        n_step      = r_step;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_slot      = r_slot;
        n_shift     = r_shift;
        n_word0     = r_word0;
        n_word1     = r_word1;
        n_lines     = r_lines;
        n_out_lines = r_lines;
        n_done      = 1'b0;
        if (!r_busy && i_q_item.kind == KIND_REQ) begin
            n_busy  = 1'b1;
            n_cmd   = i_q_item.cmd;
            n_dev   = i_q_item.slave_addr;
            n_reg   = i_q_item.reg_index;
            n_data  = i_q_item.wr_data;
            n_step  = '0;
            n_phase = '0;
            n_bit   = '0;
            n_slot  = '0;
            n_shift = '0;
            n_word0 = '0;
            n_word1 = '0;
        end else if (r_busy && i_q_item.kind == KIND_TICK) begin
            n_out_lines = w_lv;
            n_lines     = w_lv;
            if (w_unit_end) begin
                n_phase = '0;
                // Sample SDA at the end of each high unit of a received bit
                if ((w_op == OP_RECV_ACK || w_op == OP_RECV_NACK) &&
                        r_step < 5'd16 && r_step[0]) begin
                    n_shift = w_rx;
                    n_bit   = r_bit + 1'b1;
                    if (r_bit == 3'd7) begin
                        n_bit = '0;
                        if (r_cmd == CMD_READ_BYTE) begin
                            if (w_k == SW'(0)) begin
                                n_word0 = {8'h00, w_rx};
                            end
                        end else if (w_k == SW'(0)) begin
                            n_word0 = {w_rx, r_word0[7:0]};
                        end else if (w_k == SW'(1)) begin
                            n_word0 = {r_word0[15:8], w_rx};
                        end else if (w_k == SW'(4)) begin
                            n_word1 = {w_rx, r_word1[7:0]};
                        end else if (w_k == SW'(5)) begin
                            n_word1 = {r_word1[15:8], w_rx};
                        end
                    end
                end
                n_step = r_step + 1'b1;
                if (n_step >= op_len(w_op)) begin
                    n_step = '0;
                    // Pull SCL low right after the ack slot of a sent byte
                    if (w_op == OP_SEND_WADDR || w_op == OP_SEND_REG ||
                            w_op == OP_SEND_DATA || w_op == OP_SEND_RADDR) begin
                        n_lines.scl = 1'b0;
                    end
                    n_slot = r_slot + 1'b1;
                    if (w_op == OP_STOP || op_of(r_cmd, n_slot) == OP_END) begin
                        n_busy  = 1'b0;
                        n_slot  = '0;
                        n_lines = LINES_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
    end

    // Update state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cmd       <= CMD_TICK;
            r_dev       <= '0;
            r_reg       <= '0;
            r_data      <= '0;
            r_step      <= '0;
            r_phase     <= '0;
            r_bit       <= '0;
            r_slot      <= '0;
            r_shift     <= '0;
            r_word0     <= '0;
            r_word1     <= '0;
            r_lines     <= LINES_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_q_valid && o_q_pop) begin
                r_busy  <= n_busy;
                r_cmd   <= n_cmd;
                r_dev   <= n_dev;
                r_reg   <= n_reg;
                r_data  <= n_data;
                r_step  <= n_step;
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_slot  <= n_slot;
                r_shift <= n_shift;
                r_word0 <= n_word0;
                r_word1 <= n_word1;
                r_lines <= n_lines;
            end
            if (o_q_pop) begin
                r_out_valid <= i_q_valid;
            end
        end
    end

    // Hold result payload until taken
    always_ff @(posedge i_clk) begin
        if (i_q_valid && o_q_pop) begin
            r_out_lines <= n_out_lines;
            r_out_busy  <= n_busy;
            r_out_done  <= n_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_out_lines.scl;
    assign o_sda_level   = r_out_lines.sda;
    assign o_sda_driving = r_out_lines.drv;
    assign o_busy_res    = r_out_busy;
    assign o_done_res    = r_out_done;
    assign o_first_word  = r_word0;
    assign o_second_word = r_word1;

endmodule

`default_nettype wire

### hw/rtl/i2c_register_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C register access master core
// Tick-paced I2C master running whole register write and read transactions.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------
//   in       | input     | i_in_valid / o_in_ready | command, addresses, data, sda
//   out      | output    | o_out_valid/i_out_ready | pin levels, busy, done, words
//   cfg      | input     | i_cfg_wr_en             | delay_ticks
//
// One beat per clock unless i_out_ready stalls; each beat is one sequencer update.
// A beat is registered first in the front queue and then in the result register.
// Reset is synchronous; no clearing pass follows it.
// The front queue still accepts during an i_out_ready stall, until both entries fill.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_register_access_master_core_defines.svh"

module i2c_register_access_master_core
    import i2cram_pkg::*;
#(
    parameter int BURST_BYTES = BURST_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [15:0]        i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_command,
    input  wire logic [6:0]         i_device_address,
    input  wire logic [7:0]         i_register_address,
    input  wire logic [7:0]         i_write_data,
    input  wire logic               i_sda_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_scl_level,
    output logic                    o_sda_level,
    output logic                    o_sda_driving,
    output logic                    o_busy_res,
    output logic                    o_done_res,
    output logic signed [15:0]      o_first_word,
    output logic signed [15:0]      o_second_word
);

    logic [15:0] r_delay_ticks;
    logic        w_q_valid;
    t_item       w_q_item;
    logic        w_q_pop;
    logic [15:0] w_first_word;
    logic [15:0] w_second_word;

    // Hold the delay unit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= DELAY_TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_delay_ticks <= i_cfg_wr_data;
        end
    end

    i2cram_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_device_address   (i_device_address),
        .i_register_address (i_register_address),
        .i_write_data       (i_write_data),
        .i_sda_in           (i_sda_in),
        .o_q_valid          (w_q_valid),
        .o_q_item           (w_q_item),
        .i_q_pop            (w_q_pop)
    );

    i2cram_back #(
        .BURST_BYTES (BURST_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_delay_ticks (r_delay_ticks),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_sda_driving (o_sda_driving),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_first_word  (w_first_word),
        .o_second_word (w_second_word)
    );

    assign o_first_word  = signed'(w_first_word);
    assign o_second_word = signed'(w_second_word);

    // Completion leaves the bus idle and the sequencer free
    `I2CRAM_ASSERT_IMP(a_done_idle, o_out_valid && o_done_res, !o_busy_res, "done while busy")
    `I2CRAM_ASSERT_IMP(a_done_levels, o_out_valid && o_done_res,
        o_scl_level && o_sda_level && o_sda_driving, "done with bus not released")
    // No result beat straight out of reset
    `I2CRAM_ASSERT_RST(a_reset_empty, $past(!i_rst_n) && i_rst_n, !o_out_valid,
        "result beat right after reset")

endmodule

`default_nettype wire

### dv/i2c_register_access_master_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master core testbench
// Streams request and tick beats into the core and keeps a cycle-free model of
// the bus sequencer that predicts the pin levels, busy/done flags and read
// words of every beat. Results are checked in order against that model while
// the sender idles in bursts and the receiver stalls on its own pattern. The
// bus delay unit is changed between phases, its extremes included.
// ----------------------------------------------------------------------------

module i2c_register_access_master_core_tb;
    import i2cram_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 100;
    localparam int REPORT_LIMIT   = 10;
    localparam int BURST_LEN_MAX  = 32;
    localparam int GAP_MAX        = 8;
    localparam int STALL_SPAN     = 32;
    localparam int SLOW_TICKS     = 40;

    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [15:0] DELAY_MIN     = 16'd1;
    localparam logic [15:0] DELAY_MAX     = 16'hFFFF;
    localparam logic [15:0] DELAY_ZERO    = 16'd0;

    // Delay units per bus operation
    localparam int UNITS_START = 8;
    localparam int UNITS_STOP  = 6;
    localparam int UNITS_SEND  = 19;
    localparam int UNITS_RECV  = 20;

    typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} t_sda_mode;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] slave_addr;
        logic [7:0] reg_index;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_bus_beat;

    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        drv;
        logic        busy;
        logic        done;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } t_pin_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    t_bus_beat   in_beat     = '0;
    logic        out_ready   = 1'b0;

    wire logic        o_in_ready;
    wire logic        o_out_valid;
    wire logic        o_scl_level;
    wire logic        o_sda_level;
    wire logic        o_sda_driving;
    wire logic        o_busy_res;
    wire logic        o_done_res;
    wire logic [15:0] o_first_word;
    wire logic [15:0] o_second_word;

    t_bus_beat   pending_beats[$];
    t_pin_result expected_pins[$];
    int          fail_count = 0;

    i2c_register_access_master_core #(
        .BURST_BYTES(BURST_BYTES_DEF)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (in_beat.cmd),
        .i_device_address   (in_beat.slave_addr),
        .i_register_address (in_beat.reg_index),
        .i_write_data       (in_beat.wr_data),
        .i_sda_in           (in_beat.sda_in),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_scl_level        (o_scl_level),
        .o_sda_level        (o_sda_level),
        .o_sda_driving      (o_sda_driving),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_first_word       (o_first_word),
        .o_second_word      (o_second_word)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bus sequencer model
    // ------------------------------------------------------------------------
    t_cmd        xfer_cmd   = CMD_TICK;
    int          seq_unit   = 0;
    int          slot_idx   = 0;
    int          bits_in    = 0;
    logic [15:0] tick_cnt   = '0;
    logic [7:0]  rx_shift   = '0;
    logic [6:0]  tgt_dev    = '0;
    logic [7:0]  tgt_reg    = '0;
    logic [7:0]  tgt_data   = '0;
    logic [15:0] rd_word0   = '0;
    logic [15:0] rd_word1   = '0;
    t_lines      lines      = LINES_IDLE;
    logic [15:0] unit_ticks = DELAY_TICKS_RESET;

    function automatic int rx_count();
        if (xfer_cmd == CMD_READ_BYTE) return 1;
        if (xfer_cmd == CMD_READ_WORD) return 2;
        return BURST_BYTES_DEF;
    endfunction

    // Map a slot of the running transaction to its bus operation
    function automatic t_op op_at(int s);
        int n;
        if (xfer_cmd == CMD_WRITE) begin
            case (s)
                0:       return OP_START;
                1:       return OP_SEND_WADDR;
                2:       return OP_SEND_REG;
                3:       return OP_SEND_DATA;
                4:       return OP_STOP;
                default: return OP_END;
            endcase
        end
        n = rx_count();
        if (s == 0 || s == 3) return OP_START;
        if (s == 1) return OP_SEND_WADDR;
        if (s == 2) return OP_SEND_REG;
        if (s == 4) return OP_SEND_RADDR;
        if (s < 5 + n) return (s == 4 + n) ? OP_RECV_NACK : OP_RECV_ACK;
        if (s == 5 + n) return OP_STOP;
        return OP_END;
    endfunction

    function automatic int op_units(t_op op);
        if (op == OP_START) return UNITS_START;
        if (op == OP_STOP) return UNITS_STOP;
        if (op == OP_RECV_ACK || op == OP_RECV_NACK) return UNITS_RECV;
        return UNITS_SEND;
    endfunction

    function automatic logic [7:0] tx_byte(t_op op);
        if (op == OP_SEND_WADDR) return {tgt_dev, ADDR_WR};
        if (op == OP_SEND_REG) return tgt_reg;
        if (op == OP_SEND_DATA) return tgt_data;
        return {tgt_dev, ADDR_RD};
    endfunction

    // Pin levels held during unit u of an operation
    function automatic t_lines op_lines(t_op op, int u);
        t_lines     l;
        logic       b;
        logic [7:0] tx;
        int         bi;
        case (op)
            OP_START: begin
                if (u < 2) l = '{drv: 1'b1, sda: lines.sda, scl: lines.scl};
                else if (u < 4) l = LINES_IDLE;
                else if (u < 6) l = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
                else l = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
            end
            OP_STOP: begin
                if (u < 2) l = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
                else if (u < 4) l = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
                else l = LINES_IDLE;
            end
            OP_RECV_ACK, OP_RECV_NACK: begin
                b = (op == OP_RECV_NACK);
                if (u < 16) l = '{drv: 1'b0, sda: 1'b1, scl: u[0]};
                else if (u == 16) l = '{drv: 1'b1, sda: 1'b1, scl: 1'b0};
                else if (u == 18) l = '{drv: 1'b1, sda: b, scl: 1'b1};
                else l = '{drv: 1'b1, sda: b, scl: 1'b0};
            end
            default: begin
                if (u < 17) begin
                    bi = (u < 16) ? (u >> 1) : 7;
                    tx = tx_byte(op);
                    l = '{drv: 1'b1, sda: tx[7 - bi], scl: (u < 16) && u[0]};
                end else begin
                    // ack slot: release SDA and let the slave answer
                    l = '{drv: 1'b0, sda: 1'b1, scl: (u == 18)};
                end
            end
        endcase
        return l;
    endfunction

    // Merge a received byte into the read words, high byte first
    function automatic void store_rx(int k, logic [7:0] b);
        if (xfer_cmd == CMD_READ_BYTE) begin
            if (k == 0) rd_word0 = {8'h00, b};
            return;
        end
        case (k)
            0: rd_word0[15:8] = b;
            1: rd_word0[7:0]  = b;
            4: rd_word1[15:8] = b;
            5: rd_word1[7:0]  = b;
            default: ;
        endcase
    endfunction

    // Advance the model by one accepted beat and return its pin result
    task automatic step_bus_model(input t_bus_beat b, output t_pin_result r);
        t_op    op;
        int     u;
        int     lim;
        t_lines lv;
        logic   done;
        lv   = lines;
        done = 1'b0;
        if (xfer_cmd == CMD_TICK && b.cmd >= CMD_WRITE && b.cmd <= CMD_BURST) begin
            // latch a new transaction
            xfer_cmd = t_cmd'(b.cmd);
            tgt_dev  = b.slave_addr;
            tgt_reg  = b.reg_index;
            tgt_data = b.wr_data;
            seq_unit = 0;
            tick_cnt = '0;
            bits_in  = 0;
            slot_idx = 0;
            rx_shift = '0;
            rd_word0 = '0;
            rd_word1 = '0;
        end else if (xfer_cmd != CMD_TICK && b.cmd == CMD_TICK) begin
            op    = op_at(slot_idx);
            u     = seq_unit;
            lim   = (unit_ticks == 0) ? 1 : int'(unit_ticks);
            lv    = op_lines(op, u);
            lines = lv;
            if (int'(tick_cnt) + 1 >= lim) begin
                tick_cnt = '0;
                // sample SDA at the end of a receive high unit
                if ((op == OP_RECV_ACK || op == OP_RECV_NACK) && u < 16 && u[0]) begin
                    rx_shift = {rx_shift[6:0], b.sda_in};
                    bits_in++;
                    if (bits_in >= 8) begin
                        store_rx(slot_idx - 5, rx_shift);
                        bits_in = 0;
                    end
                end
                seq_unit++;
                if (seq_unit >= op_units(op)) begin
                    seq_unit = 0;
                    if (op == OP_SEND_WADDR || op == OP_SEND_REG ||
                        op == OP_SEND_DATA || op == OP_SEND_RADDR) begin
                        lines.scl = 1'b0;
                    end
                    slot_idx++;
                    if (op == OP_STOP || op_at(slot_idx) == OP_END) begin
                        xfer_cmd = CMD_TICK;
                        slot_idx = 0;
                        lines    = LINES_IDLE;
                        done     = 1'b1;
                    end
                end
            end else begin
                tick_cnt++;
            end
        end
        r.scl         = lv.scl;
        r.sda         = lv.sda;
        r.drv         = lv.drv;
        r.busy        = (xfer_cmd != CMD_TICK);
        r.done        = done;
        r.first_word  = rd_word0;
        r.second_word = rd_word1;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of beats with random gaps
    // ------------------------------------------------------------------------
    int          burst_left = 1;
    int          gap_left   = 0;
    t_pin_result drv_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                step_bus_model(in_beat, drv_want);
                expected_pins.push_back(drv_want);
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(BURST_LEN_MAX, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0
                                                                 : $urandom_range(GAP_MAX, 1);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output ready: stall on a pattern refreshed every span
    // ------------------------------------------------------------------------
    logic [31:0] stall_pat = '1;
    int          stall_pos = 0;

    always @(posedge i_clk) begin
        if (stall_pos == 0) begin
            case ($urandom_range(3, 0))
                0:       stall_pat = '1;
                1:       stall_pat = $urandom & $urandom;
                default: stall_pat = $urandom | $urandom;
            endcase
        end
        out_ready <= stall_pat[stall_pos];
        stall_pos = (stall_pos + 1) % STALL_SPAN;
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    t_pin_result mon_got;
    t_pin_result mon_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            mon_got = '{scl: o_scl_level, sda: o_sda_level, drv: o_sda_driving,
                        busy: o_busy_res, done: o_done_res,
                        first_word: o_first_word, second_word: o_second_word};
            if (expected_pins.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] result beat with no prediction pending", $realtime);
            end else begin
                mon_want = expected_pins.pop_front();
                if (mon_got.scl !== mon_want.scl || mon_got.sda !== mon_want.sda ||
                    mon_got.drv !== mon_want.drv || mon_got.busy !== mon_want.busy ||
                    mon_got.done !== mon_want.done ||
                    mon_got.first_word !== mon_want.first_word ||
                    mon_got.second_word !== mon_want.second_word) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("[%0t] mismatch exp scl=%b sda=%b drv=%b busy=%b done=%b w0=%h w1=%h",
                                 $realtime, mon_want.scl, mon_want.sda, mon_want.drv,
                                 mon_want.busy, mon_want.done, mon_want.first_word,
                                 mon_want.second_word);
                        $display("          got scl=%b sda=%b drv=%b busy=%b done=%b w0=%h w1=%h",
                                 mon_got.scl, mon_got.sda, mon_got.drv, mon_got.busy,
                                 mon_got.done, mon_got.first_word, mon_got.second_word);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no beat moves for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic pick_sda(t_sda_mode mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(1, 0));
    endfunction

    task automatic push_req(input logic [2:0] cmd, input logic [6:0] dev,
                            input logic [7:0] ra, input logic [7:0] wd);
        pending_beats.push_back('{cmd: cmd, slave_addr: dev, reg_index: ra, wr_data: wd,
                                  sda_in: 1'($urandom_range(1, 0))});
    endtask

    // Ticks carry random junk in the request fields so every bit toggles
    task automatic push_ticks(input int n, input t_sda_mode mode);
        int i;
        for (i = 0; i < n; i++) begin
            pending_beats.push_back('{cmd: CMD_TICK,
                                      slave_addr: 7'($urandom_range(127, 0)),
                                      reg_index: 8'($urandom_range(255, 0)),
                                      wr_data: 8'($urandom_range(255, 0)),
                                      sda_in: pick_sda(mode)});
        end
    endtask

    task automatic push_noise();
        if ($urandom_range(1, 0) == 0)
            push_req(3'($urandom_range(CMD_BURST, CMD_WRITE)), 7'($urandom_range(127, 0)),
                     8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
        else
            push_req(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                     7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)),
                     8'($urandom_range(255, 0)));
    endtask

    // Ticks a whole transaction needs at the current delay unit
    function automatic int xfer_ticks(t_cmd c);
        int units;
        int lim;
        lim = (unit_ticks == 0) ? 1 : int'(unit_ticks);
        case (c)
            CMD_WRITE:     units = UNITS_START + 3 * UNITS_SEND + UNITS_STOP;
            CMD_READ_BYTE: units = 2 * UNITS_START + 3 * UNITS_SEND + UNITS_RECV + UNITS_STOP;
            CMD_READ_WORD: units = 2 * UNITS_START + 3 * UNITS_SEND + 2 * UNITS_RECV + UNITS_STOP;
            default:       units = 2 * UNITS_START + 3 * UNITS_SEND
                                   + BURST_BYTES_DEF * UNITS_RECV + UNITS_STOP;
        endcase
        return units * lim;
    endfunction

    task automatic run_xfer(input t_cmd c, input logic [6:0] dev, input logic [7:0] ra,
                            input logic [7:0] wd, input t_sda_mode mode);
        push_req(c, dev, ra, wd);
        push_ticks(xfer_ticks(c), mode);
    endtask

    // Hold until every beat is through, then let the pipeline drain
    task automatic settle();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || in_valid || expected_pins.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_delay(input logic [15:0] v);
        settle();
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en  <= 1'b0;
        unit_ticks = v;
    endtask

    // Mostly whole transactions, some cut short, with stray beats mixed in
    task automatic random_phase(input int quota);
        int        counted;
        int        n;
        int        i;
        t_cmd      c;
        t_sda_mode mode;
        counted = 0;
        while (counted < quota) begin
            c = t_cmd'($urandom_range(CMD_BURST, CMD_WRITE));
            case ($urandom_range(9, 0))
                0:       mode = SDA_LOW;
                1:       mode = SDA_HIGH;
                default: mode = SDA_RANDOM;
            endcase
            push_req(c, 7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)),
                     8'($urandom_range(255, 0)));
            n = xfer_ticks(c);
            if ($urandom_range(9, 0) == 0) n = $urandom_range(n - 1, 0);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(39, 0) == 0) push_noise();
                push_ticks(1, mode);
            end
            counted += 1 + n;
            push_ticks($urandom_range(3, 0), SDA_RANDOM);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset delay unit: idle beats, then a register write past its first units
        push_ticks(2, SDA_RANDOM);
        push_req(CMD_UNUSED_LO, 7'h7F, 8'hFF, 8'hFF);
        push_req(CMD_WRITE, 7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)));
        push_ticks(2 * int'(DELAY_TICKS_RESET) + 5, SDA_RANDOM);

        // Fastest bus: finish that write, then field extremes and ignored requests
        load_delay(DELAY_MIN);
        push_ticks(xfer_ticks(CMD_WRITE), SDA_RANDOM);
        push_req(CMD_UNUSED_HI, 7'h00, 8'h00, 8'h00);
        push_req(CMD_WRITE, 7'h7F, 8'hFF, 8'hFF);
        push_ticks(10, SDA_RANDOM);
        push_req(CMD_BURST, 7'h00, 8'h00, 8'h00);
        push_req(CMD_UNUSED_LO, 7'h55, 8'hAA, 8'h55);
        push_ticks(xfer_ticks(CMD_WRITE) - 10, SDA_RANDOM);
        run_xfer(CMD_READ_BYTE, 7'h55, 8'hAA, 8'h00, SDA_HIGH);
        run_xfer(CMD_READ_WORD, 7'h2A, 8'h55, 8'hFF, SDA_LOW);
        run_xfer(CMD_BURST, 7'h7F, 8'h00, 8'hFF, SDA_HIGH);
        push_ticks(2, SDA_RANDOM);

        // Zero delay unit behaves as one tick per unit
        load_delay(DELAY_ZERO);
        run_xfer(CMD_READ_BYTE, 7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), SDA_RANDOM);

        // Slowest bus: start a write, then finish it fast
        load_delay(DELAY_MAX);
        push_req(CMD_WRITE, 7'($urandom_range(127, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)));
        push_ticks(SLOW_TICKS, SDA_RANDOM);
        load_delay(DELAY_MIN);
        push_ticks(xfer_ticks(CMD_WRITE) + 4, SDA_RANDOM);

        // Random transactions over a few delay units
        load_delay(DELAY_MIN);
        random_phase(PHASE_ITEMS);
        load_delay(16'd2);
        random_phase(PHASE_ITEMS);
        load_delay(16'd3);
        random_phase(PHASE_ITEMS);

        settle();
        if (fail_count == 0 && expected_pins.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
